FILE: hw/rtl/fully_assoc_lru_cache_ctrl_unit_defines.svh
// Assertion macros of the cache controller port checker.
`ifndef FULLY_ASSOC_LRU_CACHE_CTRL_UNIT_DEFINES_SVH
`define FULLY_ASSOC_LRU_CACHE_CTRL_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define FLAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FLAC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/flac_pkg.sv
// Package: sizes, codes and types of the cache controller.
package flac_pkg;

    localparam int WAYS          = 8;
    localparam int BLOCK_BYTES   = 64;
    localparam int ADDR_BITS     = 32;
    localparam int OFFSET_BITS   = $clog2(BLOCK_BYTES);
    localparam int BLOCK_BITS    = ADDR_BITS - OFFSET_BITS;
    localparam int WAY_BITS      = $clog2(WAYS);
    localparam int FILL_BITS     = $clog2(WAYS + 1);
    localparam int CNT_BITS      = 32;
    localparam int IN_DATA_BITS  = ((ADDR_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS  = 1 + WAY_BITS + OFFSET_BITS + BLOCK_BITS + 1 + BLOCK_BITS
                                   + 4 * CNT_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef logic [BLOCK_BITS-1:0] block_t;
    typedef logic [WAY_BITS-1:0]   way_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } state_t;

    typedef struct packed {
        logic   hit;
        way_t   hit_way;
        way_t   hit_rank;
        logic   old;
        way_t   old_way;
        logic   old_dirty;
        block_t old_tag;
    } chain_t;

    typedef struct packed {
        logic   en;
        way_t   way;
        way_t   rank;
        logic   miss;
        logic   wr;
        block_t tag;
    } update_t;

endpackage

FILE: hw/rtl/flac_way_cell.sv
// One way of the cache: tag, valid, dirty and recency rank, with chain links.
module flac_way_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  flac_pkg::way_t    idx,
    input  flac_pkg::update_t upd,
    input  flac_pkg::chain_t  chain_in,
    output flac_pkg::chain_t  chain_out
);

    flac_pkg::block_t tag_reg;
    flac_pkg::block_t tag_next;
    logic             valid_reg;
    logic             valid_next;
    logic             dirty_reg;
    logic             dirty_next;
    flac_pkg::way_t   rank_reg;
    flac_pkg::way_t   rank_next;
    logic             match;
    logic             oldest;

    assign match  = valid_reg && (tag_reg == upd.tag);
    assign oldest = (rank_reg == flac_pkg::WAY_BITS'(flac_pkg::WAYS - 1));

    always_comb
    begin
        chain_out = chain_in;
        chain_out.hit = chain_in.hit | match;
        if (!chain_in.hit && match)
        begin
            chain_out.hit_way  = idx;
            chain_out.hit_rank = rank_reg;
        end
        chain_out.old = chain_in.old | oldest;
        if (!chain_in.old && oldest)
        begin
            chain_out.old_way   = idx;
            chain_out.old_dirty = dirty_reg;
            chain_out.old_tag   = tag_reg;
        end
    end

    always_comb
    begin
        tag_next   = tag_reg;
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        rank_next  = rank_reg;
        if (upd.en)
        begin
            if (upd.way == idx)
            begin
                rank_next = '0;
                if (upd.miss)
                begin
                    tag_next   = upd.tag;
                    valid_next = 1'b1;
                    dirty_next = upd.wr;
                end
                else
                begin
                    dirty_next = dirty_reg | upd.wr;
                end
            end
            else if (valid_reg && (rank_reg < upd.rank))
            begin
                rank_next = rank_reg + flac_pkg::WAY_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            rank_reg  <= flac_pkg::WAY_BITS'(flac_pkg::WAYS - 1);
        end
        else
        begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

endmodule

FILE: hw/rtl/flac_way_chain.sv
// Row of way cells; hit and victim search ripples from way 0 upward.
module flac_way_chain (
    input  logic              clk,
    input  logic              rst_n,
    input  flac_pkg::update_t upd,
    output flac_pkg::chain_t  result
);

    flac_pkg::chain_t link [flac_pkg::WAYS+1];

    assign link[0] = '0;
    assign result  = link[flac_pkg::WAYS];

    for (genvar g = 0; g < flac_pkg::WAYS; g++)
    begin : g_cell
        flac_way_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (flac_pkg::WAY_BITS'(g)),
            .upd       (upd),
            .chain_in  (link[g]),
            .chain_out (link[g+1])
        );
    end

endmodule

FILE: hw/rtl/fully_assoc_lru_cache_ctrl_unit.sv
// Tag, LRU replacement and dirty control of a fully associative write-back cache.
// Each access is first registered in the idle state; in the lookup state the tag compare
// and oldest-way search ripple through the row of way cells, and once the result register
// is free the cells, counters and result register are updated. The next access is taken
// once the result is registered; while the result stays untaken the block holds the pending access.
module fully_assoc_lru_cache_ctrl_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [flac_pkg::IN_DATA_BITS-1:0]  s_tdata,   // address
    input  logic [0:0]                         s_tuser,   // mode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // hit, way, byte_offset, fill_block, writeback, writeback_block,
    // read_accesses, read_misses, write_accesses, write_misses, zero pad
    output logic [flac_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    flac_pkg::state_t  state_reg;
    flac_pkg::state_t  state_next;
    logic              mode_reg;
    logic [flac_pkg::ADDR_BITS-1:0] addr_reg;

    logic [flac_pkg::FILL_BITS-1:0] fill_count_reg;
    logic [flac_pkg::FILL_BITS-1:0] fill_count_next;
    logic [flac_pkg::CNT_BITS-1:0]  rd_cnt_reg;
    logic [flac_pkg::CNT_BITS-1:0]  rd_cnt_next;
    logic [flac_pkg::CNT_BITS-1:0]  rd_miss_reg;
    logic [flac_pkg::CNT_BITS-1:0]  rd_miss_next;
    logic [flac_pkg::CNT_BITS-1:0]  wr_cnt_reg;
    logic [flac_pkg::CNT_BITS-1:0]  wr_cnt_next;
    logic [flac_pkg::CNT_BITS-1:0]  wr_miss_reg;
    logic [flac_pkg::CNT_BITS-1:0]  wr_miss_next;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             hit_reg;
    flac_pkg::way_t                   way_reg;
    logic [flac_pkg::OFFSET_BITS-1:0] offset_reg;
    flac_pkg::block_t                 fill_reg;
    logic                             wb_reg;
    flac_pkg::block_t                 wb_block_reg;

    logic              accept;
    logic              commit;
    logic              full;
    logic              is_write;
    logic              wb;
    flac_pkg::block_t  block;
    flac_pkg::way_t    way_sel;
    flac_pkg::update_t upd;
    flac_pkg::chain_t  res;

    assign accept   = s_tvalid && s_tready;
    assign block    = addr_reg[flac_pkg::ADDR_BITS-1:flac_pkg::OFFSET_BITS];
    assign is_write = (mode_reg == flac_pkg::MODE_WRITE);
    assign full     = (fill_count_reg == flac_pkg::FILL_BITS'(flac_pkg::WAYS));
    assign wb       = !res.hit && full && res.old && res.old_dirty;

    always_comb
    begin
        if (res.hit)
            way_sel = res.hit_way;
        else if (!full)
            way_sel = fill_count_reg[flac_pkg::WAY_BITS-1:0];
        else if (res.old)
            way_sel = res.old_way;
        else
            way_sel = '0;
    end

    always_comb
    begin
        upd.en   = commit;
        upd.way  = way_sel;
        upd.rank = res.hit ? res.hit_rank : flac_pkg::WAY_BITS'(flac_pkg::WAYS - 1);
        upd.miss = !res.hit;
        upd.wr   = is_write;
        upd.tag  = block;
    end

    flac_way_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (upd),
        .result (res)
    );

    always_comb
    begin
        state_next      = state_reg;
        s_tready        = 1'b0;
        commit          = 1'b0;
        out_valid_next  = out_valid_reg && !m_tready;
        fill_count_next = fill_count_reg;
        rd_cnt_next     = rd_cnt_reg;
        rd_miss_next    = rd_miss_reg;
        wr_cnt_next     = wr_cnt_reg;
        wr_miss_next    = wr_miss_reg;
        case (state_reg)
            flac_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = flac_pkg::ST_LOOK;
            end
            flac_pkg::ST_LOOK:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    commit         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = flac_pkg::ST_IDLE;
                    if (!res.hit && !full)
                        fill_count_next = fill_count_reg + flac_pkg::FILL_BITS'(1);
                    if (is_write)
                    begin
                        wr_cnt_next = wr_cnt_reg + flac_pkg::CNT_BITS'(1);
                        if (!res.hit)
                            wr_miss_next = wr_miss_reg + flac_pkg::CNT_BITS'(1);
                    end
                    else
                    begin
                        rd_cnt_next = rd_cnt_reg + flac_pkg::CNT_BITS'(1);
                        if (!res.hit)
                            rd_miss_next = rd_miss_reg + flac_pkg::CNT_BITS'(1);
                    end
                end
            end
            default:
            begin
                state_next = flac_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= flac_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            fill_count_reg <= '0;
            rd_cnt_reg     <= '0;
            rd_miss_reg    <= '0;
            wr_cnt_reg     <= '0;
            wr_miss_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            fill_count_reg <= fill_count_next;
            rd_cnt_reg     <= rd_cnt_next;
            rd_miss_reg    <= rd_miss_next;
            wr_cnt_reg     <= wr_cnt_next;
            wr_miss_reg    <= wr_miss_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= s_tuser[0];
            addr_reg <= s_tdata[flac_pkg::ADDR_BITS-1:0];
        end
        if (commit)
        begin
            hit_reg      <= res.hit;
            way_reg      <= way_sel;
            offset_reg   <= addr_reg[flac_pkg::OFFSET_BITS-1:0];
            fill_reg     <= res.hit ? '0 : block;
            wb_reg       <= wb;
            wb_block_reg <= wb ? res.old_tag : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = flac_pkg::OUT_DATA_BITS'({wr_miss_reg, wr_cnt_reg, rd_miss_reg, rd_cnt_reg,
                                                 wb_block_reg, wb_reg, fill_reg, offset_reg,
                                                 way_reg, hit_reg});

endmodule

FILE: hw/rtl/flac_checker.sv
// Port checker of the cache controller and its bind to the top level.
`include "fully_assoc_lru_cache_ctrl_unit_defines.svh"

module flac_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [flac_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    localparam int HIT_POS = 0;
    localparam int FILL_LO = 1 + flac_pkg::WAY_BITS + flac_pkg::OFFSET_BITS;
    localparam int FILL_HI = FILL_LO + flac_pkg::BLOCK_BITS - 1;
    localparam int WB_POS  = FILL_HI + 1;
    localparam int WBB_LO  = WB_POS + 1;
    localparam int WBB_HI  = WBB_LO + flac_pkg::BLOCK_BITS - 1;

    `FLAC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `FLAC_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "second access taken while one is in work")
    `FLAC_ASSERT(a_hit_no_fill, m_tvalid && m_tdata[HIT_POS] |-> m_tdata[FILL_HI:FILL_LO] == '0 && !m_tdata[WB_POS], "hit reports a fill or writeback")
    `FLAC_ASSERT(a_wb_block_zero, m_tvalid && !m_tdata[WB_POS] |-> m_tdata[WBB_HI:WBB_LO] == '0, "writeback block set without writeback")

endmodule

bind fully_assoc_lru_cache_ctrl_unit flac_checker u_flac_checker (.*);

FILE: sim/fully_assoc_lru_cache_ctrl_unit_checker.sv
// Checker for the cache controller: watches both streams, predicts each access, compares results.
module fully_assoc_lru_cache_ctrl_unit_checker
    import flac_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // address
    input  logic [0:0]               s_tuser,   // mode
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    // hit, way, byte_offset, fill_block, writeback, writeback_block,
    // read_accesses, read_misses, write_accesses, write_misses, zero pad
    input  logic [OUT_DATA_BITS-1:0] m_tdata,
    output int                       fail_count,
    output int                       pending,
    output int                       hit_seen,
    output int                       wb_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [CNT_BITS-1:0] count_t;

    // Lowest field last, so a cast of the output word unpacks it.
    typedef struct packed {
        count_t                 write_misses;
        count_t                 write_accesses;
        count_t                 read_misses;
        count_t                 read_accesses;
        block_t                 writeback_block;
        logic                   writeback;
        block_t                 fill_block;
        logic [OFFSET_BITS-1:0] byte_offset;
        way_t                   way;
        logic                   hit;
    } access_result_t;

    block_t         tags [WAYS];
    way_t           rank [WAYS];
    logic           dirty [WAYS];
    int             filled;
    count_t         read_total;
    count_t         read_miss_total;
    count_t         write_total;
    count_t         write_miss_total;
    access_result_t expected_results [$];

    function automatic access_result_t cache_lookup(logic mode, logic [ADDR_BITS-1:0] addr);
        access_result_t r;
        block_t         blk;
        int             w;
        logic           wr;
        blk           = addr[ADDR_BITS-1:OFFSET_BITS];
        wr            = (mode == MODE_WRITE);
        r             = '0;
        r.byte_offset = addr[OFFSET_BITS-1:0];
        w             = 0;
        if (wr)
            write_total++;
        else
            read_total++;
        for (int i = 0; i < filled; i++)
        begin
            if (!r.hit && tags[i] == blk)
            begin
                r.hit = 1'b1;
                w     = i;
            end
        end
        if (!r.hit)
        begin
            r.fill_block = blk;
            if (filled < WAYS)
            begin
                w = filled;
                filled++;
            end
            else
            begin
                // pick the lowest way that holds the oldest rank, way 0 if none
                w = 0;
                for (int i = WAYS - 1; i >= 0; i--)
                    if (rank[i] == way_t'(WAYS - 1))
                        w = i;
                if (dirty[w])
                begin
                    r.writeback       = 1'b1;
                    r.writeback_block = tags[w];
                end
            end
            tags[w]  = blk;
            dirty[w] = 1'b0;
            if (wr)
                write_miss_total++;
            else
                read_miss_total++;
        end
        if (wr)
            dirty[w] = 1'b1;
        for (int i = 0; i < filled; i++)
            if (i != w && rank[i] < rank[w])
                rank[i]++;
        rank[w]          = '0;
        r.way            = way_t'(w);
        r.read_accesses  = read_total;
        r.read_misses    = read_miss_total;
        r.write_accesses = write_total;
        r.write_misses   = write_miss_total;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            fail_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        access_result_t got;
        access_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < WAYS; i++)
            begin
                tags[i]  = '0;
                rank[i]  = way_t'(WAYS - 1);
                dirty[i] = 1'b0;
            end
            filled           = 0;
            read_total       = '0;
            read_miss_total  = '0;
            write_total      = '0;
            write_miss_total = '0;
            expected_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = access_result_t'(m_tdata[OUT_RAW_BITS-1:0]);
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $error("result word with no access outstanding: 0x%0h", m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("hit", 64'(want.hit), 64'(got.hit));
                    check_field("way", 64'(want.way), 64'(got.way));
                    check_field("byte_offset", 64'(want.byte_offset), 64'(got.byte_offset));
                    check_field("fill_block", 64'(want.fill_block), 64'(got.fill_block));
                    check_field("writeback", 64'(want.writeback), 64'(got.writeback));
                    check_field("writeback_block", 64'(want.writeback_block),
                                64'(got.writeback_block));
                    check_field("read_accesses", 64'(want.read_accesses),
                                64'(got.read_accesses));
                    check_field("read_misses", 64'(want.read_misses), 64'(got.read_misses));
                    check_field("write_accesses", 64'(want.write_accesses),
                                64'(got.write_accesses));
                    check_field("write_misses", 64'(want.write_misses), 64'(got.write_misses));
                    if (want.hit)
                        hit_seen++;
                    if (want.writeback)
                        wb_seen++;
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(cache_lookup(s_tuser[0], s_tdata[ADDR_BITS-1:0]));
        end
        pending <= expected_results.size();
    end

endmodule

FILE: sim/tb_fully_assoc_lru_cache_ctrl_unit.sv
// Testbench top for the cache controller: clock, reset, access stimulus, result stalls, verdict.
module tb_fully_assoc_lru_cache_ctrl_unit;
    import flac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIRECTED_ACCESSES = 15;
    localparam int RANDOM_ACCESSES   = 1235;
    localparam int TOTAL_ACCESSES    = DIRECTED_ACCESSES + RANDOM_ACCESSES;
    localparam int CALM_TAIL         = 150;
    localparam int HOT_COUNT         = 12;
    localparam int LONG_HOLD         = 64;
    localparam int LIMIT_CYCLES      = 200000;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;   // address
    logic [0:0]               s_tuser;   // mode
    logic                     m_tvalid;
    logic                     m_tready;
    // hit, way, byte_offset, fill_block, writeback, writeback_block,
    // read_accesses, read_misses, write_accesses, write_misses, zero pad
    logic [OUT_DATA_BITS-1:0] m_tdata;

    int     fail_count;
    int     pending;
    int     hit_seen;
    int     wb_seen;
    block_t hot_blocks [HOT_COUNT];
    block_t last_block;

    fully_assoc_lru_cache_ctrl_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fully_assoc_lru_cache_ctrl_unit_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .hit_seen   (hit_seen),
        .wb_seen    (wb_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Present one word and hold it until taken.
    task automatic issue_access(logic mode, logic [ADDR_BITS-1:0] addr);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= addr;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [ADDR_BITS-1:0] pick_address();
        int     sel;
        block_t blk;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return ADDR_BITS'($urandom);
        if (sel < 22)
            blk = last_block;
        else
            blk = hot_blocks[$urandom_range(0, HOT_COUNT - 1)];
        last_block = blk;
        return {blk, OFFSET_BITS'($urandom)};
    endfunction

    // Result side: short random stalls, two long holds, none near the end.
    initial
    begin
        int taken;
        int stall_left;
        bit first_hold_done;
        bit second_hold_done;
        taken            = 0;
        stall_left       = 0;
        first_hold_done  = 0;
        second_hold_done = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                taken++;
            if (stall_left > 0)
                stall_left--;
            else if (taken >= 100 && !first_hold_done)
            begin
                first_hold_done = 1;
                stall_left      = LONG_HOLD;
            end
            else if (taken >= 700 && !second_hold_done)
            begin
                second_hold_done = 1;
                stall_left       = LONG_HOLD;
            end
            else if (taken < TOTAL_ACCESSES - CALM_TAIL && (taken / 50) % 3 != 1
                     && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 5);
            m_tready <= rst_n && (stall_left == 0);
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        last_block = '0;
        for (int i = 0; i < HOT_COUNT; i++)
            hot_blocks[i] = block_t'($urandom);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill, offset extremes, hits on clean and dirty ways
        issue_access(MODE_READ, 32'h0000_0000);
        issue_access(MODE_WRITE, 32'hFFFF_FFFF);
        issue_access(MODE_WRITE, 32'h0000_003F);
        issue_access(MODE_READ, 32'hFFFF_FFC0);
        for (int b = 1; b <= 6; b++)
            issue_access(b[0] ? MODE_READ : MODE_WRITE, {block_t'(b), OFFSET_BITS'(b * 9)});
        // all ways full: dirty, dirty, clean evictions, write hit on a clean way, refetch
        issue_access(MODE_READ, {block_t'(26'h100), 6'h15});
        issue_access(MODE_WRITE, {block_t'(26'h200), 6'h2A});
        issue_access(MODE_READ, {block_t'(26'h300), 6'h01});
        issue_access(MODE_WRITE, {block_t'(26'h3), 6'h00});
        issue_access(MODE_READ, 32'h0000_0000);
        drain_results();

        for (int n = 0; n < RANDOM_ACCESSES; n++)
        begin
            if (n == RANDOM_ACCESSES / 2)
                drain_results();
            if (n % 20 == 0)
                hot_blocks[$urandom_range(0, HOT_COUNT - 1)] = block_t'($urandom);
            if (n < RANDOM_ACCESSES - CALM_TAIL && (n / 60) % 3 != 2 && $urandom_range(0, 6) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            issue_access(1'($urandom), pick_address());
        end
        drain_results();
        repeat (8) @(posedge clk);

        $display("Covered %0d accesses: directed fills, hits and evictions, then pooled random",
                 TOTAL_ACCESSES);
        $display("traffic under stalls; %0d hits and %0d dirty writebacks seen.", hit_seen, wb_seen);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
